/* sv/vau_pkg.sv */
// shared types, constants and helpers of the four-component vector alu
package vau_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_BITS  = 32;
   localparam int FIELD_W    = 32;
   localparam int SAT_W      = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
   localparam int CMD_W      = 4;
   localparam int EPS_W      = 16;
   localparam int LANES      = 4;
   localparam int IN_DATA_W  = 9 * FIELD_W;
   localparam int OUT_DATA_W = 5 * FIELD_W;
   localparam int OUT_USER_W = 3;

   // square root chain: one root bit per cell
   localparam int ROOT_W   = FIELD_W;
   localparam int RAD_W    = 2 * ROOT_W;
   localparam int SQREM_W  = ROOT_W + 2;
   localparam int SQ_CELLS = ROOT_W;

   // divider chain: one quotient bit per cell
   localparam int NUM_W    = FIELD_W + FRAC_BITS;
   localparam int DEN_W    = FIELD_W + 1;
   localparam int DV_CELLS = NUM_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 4'd0,
      CMD_SUB   = 4'd1,
      CMD_NEG   = 4'd2,
      CMD_SCALE = 4'd3,
      CMD_DIV   = 4'd4,
      CMD_DOT   = 4'd5,
      CMD_CROSS = 4'd6,
      CMD_MAG   = 4'd7,
      CMD_NORM  = 4'd8
   } cmd_type;

   typedef logic signed [FIELD_W-1:0] word_type;

   // side data carried along the square root chain
   typedef struct packed {
      cmd_type                 cmd;
      logic [LANES-1:0][FIELD_W-1:0] r;
      logic [FIELD_W-1:0]      sc;
      logic [LANES-1:0][FIELD_W-1:0] a;
      logic [FIELD_W-1:0]      f;
      logic                    ovf;
      logic                    pt;
      logic                    vec;
   } sq_side_type;

   // side data carried along the divider chain
   typedef struct packed {
      cmd_type                 cmd;
      logic [LANES-1:0][FIELD_W-1:0] r;
      logic [FIELD_W-1:0]      sc;
      logic                    err;
      logic                    pt;
      logic                    vec;
      logic [LANES-1:0]        qneg;
      logic [LANES-1:0]        anz;
   } dv_side_type;

   // clamp to the result word range
   function automatic logic [FIELD_W-1:0] sat_word(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      logic signed [63:0] r;
      hi = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r[FIELD_W-1:0];
   endfunction

endpackage

/* sv/vec4_arith_unit.sv */
// top level of the four-component fixed-point vector alu
// every item runs the same 85-stage pipeline and one item is taken each cycle unless stalled:
// input register, multiply stage (scale, dot, cross and square products), combine
// stage (sums, shifts, saturation), a chain of 32 square root cells (one root bit
// each), a divider setup stage, a chain of 48 divider cells (one quotient bit per
// lane each) and the output register. the whole pipeline advances when the output
// register is empty or being taken, so a stalled result holds every stage in place.
// epsilon resets to 1
module vec4_arith_unit import vau_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // ax, ay, az, aw, bx, by, bz, bw, factor (32 bits each, lowest first)
   input  logic [IN_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic [CMD_W-1:0]      req_tuser,
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rx, ry, rz, rw, scalar_out (32 bits each, lowest first)
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   // is_point, is_vector, error
   output logic [OUT_USER_W-1:0] rsp_tuser,
   // epsilon register
   input  logic                  csr_wr_en,
   input  logic [EPS_W-1:0]      csr_wr_data
);

   logic adv;

   // epsilon register
   logic [EPS_W-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_W'(1);
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   // input stage
   logic     v0_ff;
   cmd_type  cmd0_ff;
   word_type a0_ff [LANES];
   word_type b0_ff [LANES];
   word_type f0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd0_ff <= cmd_type'(req_tuser);
         for (int i = 0; i < LANES; i++) begin
            a0_ff[i] <= req_tdata[i*FIELD_W +: FIELD_W];
            b0_ff[i] <= req_tdata[(LANES+i)*FIELD_W +: FIELD_W];
         end
         f0_ff <= req_tdata[2*LANES*FIELD_W +: FIELD_W];
      end
   end

   // multiply stage: lane products, cross products, squares, simple ops, flags
   logic               v1_ff;
   cmd_type            cmd1_ff;
   logic signed [63:0] lp1_ff [LANES];
   logic signed [63:0] cp1_ff [6];
   logic signed [63:0] sq1_ff [LANES];
   logic [FIELD_W-1:0] simple1_ff [LANES];
   word_type           a1_ff [LANES];
   word_type           f1_ff;
   logic               pt1_ff, vec1_ff;

   word_type           lop [LANES];
   logic [FIELD_W-1:0] simple_in [LANES];
   logic signed [63:0] dpt, dvc;
   logic               pt_in, vec_in;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lop[i] = (cmd0_ff == CMD_SCALE) ? f0_ff : b0_ff[i];
         case (cmd0_ff)
            CMD_ADD: simple_in[i] = sat_word(64'(a0_ff[i]) + 64'(b0_ff[i]));
            CMD_SUB: simple_in[i] = sat_word(64'(a0_ff[i]) - 64'(b0_ff[i]));
            CMD_NEG: simple_in[i] = sat_word(-64'(a0_ff[i]));
            default: simple_in[i] = '0;
         endcase
      end
      // tolerance tests on w against one and zero
      dpt    = 64'(a0_ff[3]) - (64'sd1 <<< FRAC_BITS);
      dvc    = 64'(a0_ff[3]);
      if (dpt < 0) dpt = -dpt;
      if (dvc < 0) dvc = -dvc;
      pt_in  = dpt < 64'(eps_ff);
      vec_in = dvc < 64'(eps_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd1_ff <= cmd0_ff;
         for (int i = 0; i < LANES; i++) begin
            lp1_ff[i]     <= 64'(a0_ff[i]) * 64'(lop[i]);
            sq1_ff[i]     <= 64'(a0_ff[i]) * 64'(a0_ff[i]);
            simple1_ff[i] <= simple_in[i];
            a1_ff[i]      <= a0_ff[i];
         end
         cp1_ff[0] <= 64'(a0_ff[1]) * 64'(b0_ff[2]);
         cp1_ff[1] <= 64'(a0_ff[2]) * 64'(b0_ff[1]);
         cp1_ff[2] <= 64'(a0_ff[2]) * 64'(b0_ff[0]);
         cp1_ff[3] <= 64'(a0_ff[0]) * 64'(b0_ff[2]);
         cp1_ff[4] <= 64'(a0_ff[0]) * 64'(b0_ff[1]);
         cp1_ff[5] <= 64'(a0_ff[1]) * 64'(b0_ff[0]);
         f1_ff   <= f0_ff;
         pt1_ff  <= pt_in;
         vec1_ff <= vec_in;
      end
   end

   // combine stage: lane and cross products shifted down (floor) before any sum; squares summed unshifted
   logic               v2_ff;
   logic [RAD_W-1:0]   rad2_ff;
   sq_side_type        sd2_ff;

   logic signed [63:0] lps [LANES];
   logic signed [63:0] cps [6];
   logic signed [63:0] dot_sum;
   logic [RAD_W+1:0]   sq_sum;
   sq_side_type        sd2_in;

   always_comb begin
      dot_sum = '0;
      sq_sum  = '0;
      for (int i = 0; i < LANES; i++) begin
         lps[i]  = lp1_ff[i] >>> FRAC_BITS;
         dot_sum = dot_sum + lps[i];
         sq_sum  = sq_sum + (RAD_W + 2)'(unsigned'(sq1_ff[i]));
      end
      for (int k = 0; k < 6; k++) begin
         cps[k] = cp1_ff[k] >>> FRAC_BITS;
      end
      sd2_in.cmd = cmd1_ff;
      for (int i = 0; i < LANES; i++) begin
         case (cmd1_ff)
            CMD_ADD, CMD_SUB, CMD_NEG: sd2_in.r[i] = simple1_ff[i];
            CMD_SCALE:                 sd2_in.r[i] = sat_word(lps[i]);
            default:                   sd2_in.r[i] = '0;
         endcase
         sd2_in.a[i] = a1_ff[i];
      end
      if (cmd1_ff == CMD_CROSS) begin
         sd2_in.r[0] = sat_word(cps[0] - cps[1]);
         sd2_in.r[1] = sat_word(cps[2] - cps[3]);
         sd2_in.r[2] = sat_word(cps[4] - cps[5]);
         sd2_in.r[3] = '0;
      end
      sd2_in.sc  = (cmd1_ff == CMD_DOT) ? sat_word(dot_sum) : '0;
      sd2_in.f   = f1_ff;
      // sum of squares past 64 bits: magnitude is taken as 2^32
      sd2_in.ovf = sq_sum[RAD_W+1:RAD_W] != 2'b00;
      sd2_in.pt  = pt1_ff;
      sd2_in.vec = vec1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad2_ff <= sq_sum[RAD_W-1:0];
         sd2_ff  <= sd2_in;
      end
   end

   // square root chain
   logic [RAD_W-1:0]   sq_rad  [SQ_CELLS+1];
   logic [SQREM_W-1:0] sq_rem  [SQ_CELLS+1];
   logic [ROOT_W-1:0]  sq_root [SQ_CELLS+1];
   logic [SQ_CELLS-1:0] sq_v_ff;
   sq_side_type         sq_side_ff [SQ_CELLS];

   assign sq_rad[0]  = rad2_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
      vau_sqrt_cell u_cell (
         .clock     (clock),
         .en        (adv),
         .rad_prev  (sq_rad[k]),
         .rem_prev  (sq_rem[k]),
         .root_prev (sq_root[k]),
         .rad_out   (sq_rad[k+1]),
         .rem_out   (sq_rem[k+1]),
         .root_out  (sq_root[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= '0;
      end else if (adv) begin
         sq_v_ff <= {sq_v_ff[SQ_CELLS-2:0], v2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= sd2_ff;
         for (int k = 1; k < SQ_CELLS; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // divider setup: divisor is |factor| or the magnitude, numerators |a| scaled up
   logic                        pv_ff;
   logic [DEN_W-1:0]            pden_ff;
   logic [LANES-1:0][NUM_W-1:0] pnum_ff;
   dv_side_type                 pside_ff;

   sq_side_type                 sqs;
   logic [DEN_W-1:0]            len, fabs, den_in;
   logic [LANES-1:0][NUM_W-1:0] num_in;
   logic [FIELD_W:0]            aabs;
   dv_side_type                 pside_in;

   always_comb begin
      sqs  = sq_side_ff[SQ_CELLS-1];
      len  = sqs.ovf ? (DEN_W'(1) << ROOT_W) : {1'b0, sq_root[SQ_CELLS]};
      fabs = sqs.f[FIELD_W-1] ? DEN_W'(-{sqs.f[FIELD_W-1], sqs.f}) : DEN_W'(sqs.f);
      pside_in.cmd = sqs.cmd;
      pside_in.r   = sqs.r;
      pside_in.pt  = sqs.pt;
      pside_in.vec = sqs.vec;
      case (sqs.cmd)
         CMD_DIV: begin
            den_in       = fabs;
            pside_in.err = fabs == '0;
            pside_in.sc  = sqs.sc;
         end
         CMD_NORM: begin
            den_in       = len;
            pside_in.err = (len == '0) || (len < DEN_W'(eps_ff));
            pside_in.sc  = sat_word(64'(len));
         end
         CMD_MAG: begin
            den_in       = len;
            pside_in.err = 1'b0;
            pside_in.sc  = sat_word(64'(len));
         end
         default: begin
            den_in       = len;
            pside_in.err = 1'b0;
            pside_in.sc  = sqs.sc;
         end
      endcase
      for (int i = 0; i < LANES; i++) begin
         aabs = sqs.a[i][FIELD_W-1] ? -{sqs.a[i][FIELD_W-1], sqs.a[i]}
                                    : {1'b0, sqs.a[i]};
         num_in[i] = {aabs[FIELD_W-1:0], {FRAC_BITS{1'b0}}};
         // quotient sign: sign of a, flipped by a negative divisor
         pside_in.qneg[i] = sqs.a[i][FIELD_W-1] ^
                            ((sqs.cmd == CMD_DIV) && sqs.f[FIELD_W-1]);
         pside_in.anz[i]  = sqs.a[i] != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (adv) begin
         pv_ff <= sq_v_ff[SQ_CELLS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pden_ff  <= den_in;
         pnum_ff  <= num_in;
         pside_ff <= pside_in;
      end
   end

   // divider chain
   logic [DEN_W-1:0]            dv_den [DV_CELLS+1];
   logic [LANES-1:0][NUM_W-1:0] dv_num [DV_CELLS+1];
   logic [LANES-1:0][DEN_W-1:0] dv_rem [DV_CELLS+1];
   logic [DV_CELLS-1:0]         dv_v_ff;
   dv_side_type                 dv_side_ff [DV_CELLS];

   assign dv_den[0] = pden_ff;
   assign dv_num[0] = pnum_ff;
   assign dv_rem[0] = '0;

   for (genvar k = 0; k < DV_CELLS; k++) begin : g_dv
      vau_div_cell u_cell (
         .clock    (clock),
         .en       (adv),
         .den_prev (dv_den[k]),
         .num_prev (dv_num[k]),
         .rem_prev (dv_rem[k]),
         .den_out  (dv_den[k+1]),
         .num_out  (dv_num[k+1]),
         .rem_out  (dv_rem[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff <= '0;
      end else if (adv) begin
         dv_v_ff <= {dv_v_ff[DV_CELLS-2:0], pv_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= pside_ff;
         for (int k = 1; k < DV_CELLS; k++) begin
            dv_side_ff[k] <= dv_side_ff[k-1];
         end
      end
   end

   // result select and output register
   dv_side_type         dvs;
   logic signed [63:0]  qval;
   logic [FIELD_W-1:0]  r_in [LANES];
   logic                rsp_valid_ff;
   logic [OUT_DATA_W-1:0] rsp_data_ff;
   logic [OUT_USER_W-1:0] rsp_user_ff;

   always_comb begin
      dvs = dv_side_ff[DV_CELLS-1];
      for (int i = 0; i < LANES; i++) begin
         qval = dvs.qneg[i] ? -64'(dv_num[DV_CELLS][i]) : 64'(dv_num[DV_CELLS][i]);
         case (dvs.cmd)
            CMD_DIV: begin
               if (!dvs.err) begin
                  r_in[i] = sat_word(qval);
               end else if (!dvs.anz[i]) begin
                  r_in[i] = '0;
               end else if (dvs.qneg[i]) begin
                  r_in[i] = sat_word(64'h8000_0000_0000_0000);
               end else begin
                  r_in[i] = sat_word(64'h7fff_ffff_ffff_ffff);
               end
            end
            CMD_NORM: r_in[i] = dvs.err ? '0 : sat_word(qval);
            default:  r_in[i] = dvs.r[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v_ff[DV_CELLS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < LANES; i++) begin
            rsp_data_ff[i*FIELD_W +: FIELD_W] <= r_in[i];
         end
         rsp_data_ff[LANES*FIELD_W +: FIELD_W] <= dvs.sc;
         rsp_user_ff <= {dvs.err, dvs.vec, dvs.pt};
      end
   end

   // whole pipeline moves when the output register is free or being drained
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // error only comes from divide or normalize
   a_err_cmd: assert property (@(posedge clock) disable iff (reset)
      (dv_v_ff[DV_CELLS-1] && dvs.err) |-> (dvs.cmd == CMD_DIV || dvs.cmd == CMD_NORM))
      else $error("error flag on a command that cannot fail");

   // a normalized component never exceeds one
   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_v_ff[DV_CELLS-1] && dvs.cmd == CMD_NORM && !dvs.err) |->
         (dv_num[DV_CELLS][0] <= (NUM_W'(1) << FRAC_BITS) &&
          dv_num[DV_CELLS][1] <= (NUM_W'(1) << FRAC_BITS) &&
          dv_num[DV_CELLS][2] <= (NUM_W'(1) << FRAC_BITS) &&
          dv_num[DV_CELLS][3] <= (NUM_W'(1) << FRAC_BITS)))
      else $error("normalize quotient above one");

   // a stall freezes occupancy of both chains
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(sq_v_ff) && $stable(dv_v_ff) && $stable(pv_ff)))
      else $error("pipeline moved during a stall");
`endif

endmodule

/* sv/vau_sqrt_cell.sv */
// one cell of the square root chain, settles one root bit
module vau_sqrt_cell import vau_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [RAD_W-1:0]   rad_prev,
   input  logic [SQREM_W-1:0] rem_prev,
   input  logic [ROOT_W-1:0]  root_prev,
   output logic [RAD_W-1:0]   rad_out,
   output logic [SQREM_W-1:0] rem_out,
   output logic [ROOT_W-1:0]  root_out
);

   logic [SQREM_W+1:0] part, trial, diff;
   logic [RAD_W-1:0]   rad_in, rad_ff;
   logic [SQREM_W-1:0] rem_in, rem_ff;
   logic [ROOT_W-1:0]  root_in, root_ff;

   always_comb begin
      part   = {rem_prev, rad_prev[RAD_W-1 -: 2]};
      trial  = (SQREM_W + 2)'({root_prev, 2'b01});
      diff   = part - trial;
      rad_in = {rad_prev[RAD_W-3:0], 2'b00};
      if (part >= trial) begin
         rem_in  = diff[SQREM_W-1:0];
         root_in = {root_prev[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = part[SQREM_W-1:0];
         root_in = {root_prev[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

/* sv/vau_div_cell.sv */
// one cell of the divider chain, settles one quotient bit in each lane
module vau_div_cell import vau_pkg::*; (
   input  logic                        clock,
   input  logic                        en,
   input  logic [DEN_W-1:0]            den_prev,
   input  logic [LANES-1:0][NUM_W-1:0] num_prev,
   input  logic [LANES-1:0][DEN_W-1:0] rem_prev,
   output logic [DEN_W-1:0]            den_out,
   output logic [LANES-1:0][NUM_W-1:0] num_out,
   output logic [LANES-1:0][DEN_W-1:0] rem_out
);

   logic [DEN_W-1:0]            den_ff;
   logic [LANES-1:0][NUM_W-1:0] num_in, num_ff;
   logic [LANES-1:0][DEN_W-1:0] rem_in, rem_ff;
   logic [DEN_W:0]              part [LANES];
   logic [DEN_W:0]              diff [LANES];

   // numerator shifts out at the top, quotient bits shift in at the bottom
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         part[i] = {rem_prev[i], num_prev[i][NUM_W-1]};
         diff[i] = part[i] - {1'b0, den_prev};
         if (part[i] >= {1'b0, den_prev}) begin
            rem_in[i] = diff[i][DEN_W-1:0];
            num_in[i] = {num_prev[i][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[i] = part[i][DEN_W-1:0];
            num_in[i] = {num_prev[i][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= den_prev;
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign den_out = den_ff;
   assign num_out = num_ff;
   assign rem_out = rem_ff;

endmodule
